@@ sv/cls_pkg.sv @@
// Package with shared types and constants of the command line splitter.
`timescale 1ns / 1ps

package cls_pkg;

  localparam int unsigned MaxRun  = 255;
  localparam int unsigned MaxArgs = 255;
  localparam int unsigned RunCap  = (MaxRun < 255) ? MaxRun : 255;
  localparam int unsigned ArgCap  = (MaxArgs < 255) ? MaxArgs : 255;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [1:0] QuoteLast = 2'd2;

  typedef enum logic [2:0] {
    PhStart       = 3'd0,
    PhFirstQuoted = 3'd1,
    PhFirstPlain  = 3'd2,
    PhGap         = 3'd3,
    PhArg         = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_end;
  } item_t;

  typedef struct packed {
    logic [7:0] backslash_count;
    logic       char_valid;
    logic [7:0] out_char;
    logic       arg_end;
    logic [7:0] arg_number;
    logic       string_done;
    logic       empty_error;
    logic       run_overflow;
  } result_t;

endpackage

@@ sv/cls_in_stage.sv @@
// Input register stage that holds one accepted item for the parser.
`timescale 1ns / 1ps

module cls_in_stage
  import cls_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

@@ sv/cls_parse.sv @@
// Parser state, per-byte splitting logic and the result register.
`timescale 1ns / 1ps

module cls_parse
  import cls_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  item_t   item_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  phase_e     phase_q, phase_d;
  logic [1:0] qc_q, qc_d;
  logic [7:0] bs_q, bs_d;
  logic       iqr_q, iqr_d;
  logic [7:0] argc_q, argc_d;
  logic       seen_q, seen_d;
  logic       out_valid_q;
  result_t    res_q, res_d;

  logic       take;
  logic [7:0] c;
  logic       blank;
  logic [1:0] qc_in;
  logic [7:0] bs_in;
  logic       iqr_in;
  logic [1:0] qc_e;

  assign ready_o     = !out_valid_q || out_ready_i;
  assign take        = valid_i && ready_o;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign c           = item_i.text_byte;
  assign blank       = (c == ChSpace) || (c == ChTab);

  always_comb begin
    phase_d = phase_q;
    qc_d    = qc_q;
    bs_d    = bs_q;
    iqr_d   = iqr_q;
    argc_d  = argc_q;
    seen_d  = seen_q;
    res_d   = '0;
    qc_in   = qc_q;
    bs_in   = bs_q;
    iqr_in  = iqr_q;
    qc_e    = qc_q;
    if (item_i.is_end) begin
      res_d.arg_number  = argc_q;
      res_d.string_done = 1'b1;
      res_d.empty_error = !seen_q;
      if (phase_q == PhFirstQuoted || phase_q == PhFirstPlain) begin
        res_d.arg_end = 1'b1;
      end else if (phase_q == PhArg) begin
        res_d.backslash_count = bs_q;
        res_d.arg_end         = 1'b1;
      end
      phase_d = PhStart;
      qc_d    = '0;
      bs_d    = '0;
      iqr_d   = 1'b0;
      argc_d  = '0;
      seen_d  = 1'b0;
    end else begin
      seen_d = 1'b1;
      case (phase_q)
        PhStart: begin
          if (c == ChQuote) begin
            phase_d = PhFirstQuoted;
          end else if (blank) begin
            res_d.arg_end = 1'b1;
            phase_d       = PhGap;
          end else begin
            res_d.char_valid = 1'b1;
            res_d.out_char   = c;
            phase_d          = PhFirstPlain;
          end
        end
        PhFirstQuoted: begin
          if (c == ChQuote) begin
            res_d.arg_end = 1'b1;
            phase_d       = PhGap;
          end else begin
            res_d.char_valid = 1'b1;
            res_d.out_char   = c;
          end
        end
        PhFirstPlain: begin
          if (blank) begin
            res_d.arg_end = 1'b1;
            phase_d       = PhGap;
          end else begin
            res_d.char_valid = 1'b1;
            res_d.out_char   = c;
          end
        end
        PhGap, PhArg: begin
          if (phase_q == PhGap && blank) begin
            res_d.arg_number = argc_q;
          end else begin
            if (phase_q == PhGap) begin
              if (argc_q < 8'(ArgCap)) begin
                argc_d = argc_q + 8'd1;
              end
              qc_in  = '0;
              bs_in  = '0;
              iqr_in = 1'b0;
            end
            phase_d          = PhArg;
            qc_d             = qc_in;
            bs_d             = bs_in;
            iqr_d            = iqr_in;
            res_d.arg_number = argc_d;
            if (c == ChQuote) begin
              if (iqr_in) begin
                if (qc_in == QuoteLast) begin
                  res_d.char_valid = 1'b1;
                  res_d.out_char   = ChQuote;
                  qc_d             = '0;
                end else begin
                  qc_d = qc_in + 2'd1;
                end
              end else begin
                iqr_d                 = 1'b1;
                res_d.backslash_count = bs_in >> 1;
                if (bs_in[0]) begin
                  res_d.char_valid = 1'b1;
                  res_d.out_char   = ChQuote;
                end else if (qc_in < QuoteLast) begin
                  qc_d = qc_in + 2'd1;
                end
                bs_d = '0;
              end
            end else begin
              iqr_d = 1'b0;
              qc_e  = (iqr_in && qc_in == QuoteLast) ? 2'd0 : qc_in;
              qc_d  = qc_e;
              if (blank && qc_e == 2'd0) begin
                res_d.backslash_count = bs_in;
                res_d.arg_end         = 1'b1;
                bs_d                  = '0;
                phase_d               = PhGap;
              end else if (c == ChBslash) begin
                if (bs_in >= 8'(RunCap)) begin
                  res_d.run_overflow = 1'b1;
                end else begin
                  bs_d = bs_in + 8'd1;
                end
              end else begin
                res_d.backslash_count = bs_in;
                res_d.char_valid      = 1'b1;
                res_d.out_char        = c;
                bs_d                  = '0;
              end
            end
          end
        end
        default: begin
          phase_d = PhStart;
          qc_d    = '0;
          bs_d    = '0;
          iqr_d   = 1'b0;
          argc_d  = '0;
          seen_d  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStart;
      qc_q        <= '0;
      bs_q        <= '0;
      iqr_q       <= 1'b0;
      argc_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
      if (take) begin
        phase_q <= phase_d;
        qc_q    <= qc_d;
        bs_q    <= bs_d;
        iqr_q   <= iqr_d;
        argc_q  <= argc_d;
        seen_q  <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

@@ sv/command_line_splitter_unit.sv @@
// Top level of the command line splitter.
// The block takes a command line one byte per transfer on the input channel
// (in_valid_i, in_ready_o, text_byte_i, is_end_i) and gives one result per
// input transfer on the output channel (out_valid_o, out_ready_i and the
// result fields). An item with is_end_i set closes the string instead of
// carrying a byte, and its result has string_done_o set.
// Each result tells how many backslashes to append, an optional character,
// whether the current argument closes, and the argument index.
// An accepted item passes an input register and then the splitting logic,
// whose result lands in the result register, from which it is offered on
// the output channel. One item is taken every cycle while the receiver
// keeps up.
// Reset clears the parser state to the start of argument zero and empties
// both registers; no result is pending after reset.
// When the receiver stalls, the result register holds, then the input
// register fills, and in_ready_o falls; nothing is lost or repeated.
`timescale 1ns / 1ps

module command_line_splitter_unit
  import cls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       is_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] backslash_count_o,
  output logic       char_valid_o,
  output logic [7:0] out_char_o,
  output logic       arg_end_o,
  output logic [7:0] arg_number_o,
  output logic       string_done_o,
  output logic       empty_error_o,
  output logic       run_overflow_o
);

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    parse_ready;
  result_t result;

  assign in_item.text_byte = text_byte_i;
  assign in_item.is_end    = is_end_i;

  cls_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .valid_o    (stage_valid),
    .ready_i    (parse_ready),
    .item_o     (stage_item)
  );

  cls_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .ready_o     (parse_ready),
    .item_i      (stage_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign backslash_count_o = result.backslash_count;
  assign char_valid_o      = result.char_valid;
  assign out_char_o        = result.out_char;
  assign arg_end_o         = result.arg_end;
  assign arg_number_o      = result.arg_number;
  assign string_done_o     = result.string_done;
  assign empty_error_o     = result.empty_error;
  assign run_overflow_o    = result.run_overflow;

endmodule

@@ sv/cls_checker.sv @@
// Port-level checker for the command line splitter and its bind statement.
`timescale 1ns / 1ps

module cls_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] backslash_count_o,
  input logic       char_valid_o,
  input logic [7:0] out_char_o,
  input logic       arg_end_o,
  input logic [7:0] arg_number_o,
  input logic       string_done_o,
  input logic       empty_error_o,
  input logic       run_overflow_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o)
      && $stable(backslash_count_o) && $stable(arg_number_o))
    else $error("Stalled result changed before its transfer.");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_error_o |-> string_done_o && !arg_end_o
      && arg_number_o == 8'd0 && backslash_count_o == 8'd0)
    else $error("Empty string result carries argument data.");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> !char_valid_o && !run_overflow_o)
    else $error("End result carries a character or an overflow.");

  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_valid_o |-> out_char_o == 8'd0)
    else $error("Character field is set without a valid character.");

  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_overflow_o |-> !arg_end_o && backslash_count_o == 8'd0)
    else $error("Overflow result releases backslashes or closes an argument.");

endmodule

bind command_line_splitter_unit cls_checker u_cls_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .backslash_count_o (backslash_count_o),
  .char_valid_o      (char_valid_o),
  .out_char_o        (out_char_o),
  .arg_end_o         (arg_end_o),
  .arg_number_o      (arg_number_o),
  .string_done_o     (string_done_o),
  .empty_error_o     (empty_error_o),
  .run_overflow_o    (run_overflow_o)
);
